// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// SHA-256 package: controller states, round constants, initial hash words
// and the sigma functions. No dependencies.
package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL,
      ST_PAD_MARK,
      ST_PAD_FILL,
      ST_OUT
   } state_type;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned NUM_ROUNDS = 64;
   localparam int unsigned BUF_DEPTH  = 16;
   localparam int unsigned BUF_AW     = 4;
   localparam int unsigned CNT_W      = 61;
   localparam int unsigned HASH_WORDS = 8;

   // buffer word slots that hold the 64-bit length
   localparam logic [BUF_AW-1:0] LEN_HI_IDX = 4'd14;
   localparam logic [BUF_AW-1:0] LEN_LO_IDX = 4'd15;
   localparam logic [5:0]        LAST_ROUND = 6'd63;
   localparam logic [2:0]        LAST_WORD  = 3'd7;
   localparam logic [7:0]        PAD_BYTE   = 8'h80;

   localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WORD_W-1:0] ROUND_K [NUM_ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                              input int unsigned n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
      ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
      ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// ===== rtl/sha256_message_hash_unit.sv =====
`timescale 1ns / 1ps
// SHA-256 hash of a byte stream: block buffer memory, one-round-per-cycle
// compression, padding sequencer and digest output. Uses sha256_pkg.
//
// One request byte is taken per cycle while idle; req_tready is low while a
// full 64-byte block goes through the single round unit (load, 64 rounds,
// hash add). A last request adds padding writes, one or two compressions
// and 8 digest words.
// Reset: initial hash, zero length, idle. The buffer memory is not cleared.
module sha256_message_hash_unit
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] hash_ff [HASH_WORDS];
   logic [WORD_W-1:0] hash_in [HASH_WORDS];
   logic [WORD_W-1:0] wv_ff [HASH_WORDS];
   logic [WORD_W-1:0] wv_in [HASH_WORDS];
   logic [WORD_W-1:0] win_ff [BUF_DEPTH];
   logic [WORD_W-1:0] win_in [BUF_DEPTH];
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic [5:0]        rnd_ff, rnd_in;
   logic [BUF_AW-1:0] wi_ff, wi_in;
   logic [2:0]        oi_ff, oi_in;
   logic              pad_ff, pad_in;
   logic              extra_ff, extra_in;
   logic              last_pend_ff, last_pend_in;

   logic [WORD_W-1:0] buf_mem [BUF_DEPTH];
   logic              mem_we;
   logic [BUF_AW-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [BUF_AW-1:0] rd_addr;

   logic              req_acc;
   logic              rsp_acc;
   logic [BUF_AW-1:0] idx;
   logic [1:0]        bpos;
   logic [WORD_W-1:0] byte_word;
   logic [WORD_W-1:0] mark_word;
   logic [WORD_W-1:0] fill_word;
   logic [WORD_W-1:0] w_cur;
   logic [WORD_W-1:0] t1;
   logic [WORD_W-1:0] t2;
   logic [WORD_W-1:0] ch;
   logic [WORD_W-1:0] maj;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign idx     = cnt_ff[5:2];
   assign bpos    = cnt_ff[1:0];

   // byte placed big-endian into the partial word
   always_comb begin
      unique case (bpos)
         2'd0: byte_word = {req_tdata, 24'h0};
         2'd1: byte_word = {acc_ff[31:24], req_tdata, 16'h0};
         2'd2: byte_word = {acc_ff[31:16], req_tdata, 8'h0};
         2'd3: byte_word = {acc_ff[31:8], req_tdata};
         default: byte_word = '0;
      endcase
   end

   always_comb begin
      unique case (bpos)
         2'd0: mark_word = {PAD_BYTE, 24'h0};
         2'd1: mark_word = {acc_ff[31:24], PAD_BYTE, 16'h0};
         2'd2: mark_word = {acc_ff[31:16], PAD_BYTE, 8'h0};
         2'd3: mark_word = {acc_ff[31:8], PAD_BYTE};
         default: mark_word = '0;
      endcase
   end

   // bit length = byte count * 8, only in the final block
   always_comb begin
      fill_word = '0;
      if (!extra_ff && wi_ff == LEN_HI_IDX) begin
         fill_word = cnt_ff[CNT_W-1:CNT_W-WORD_W];
      end else if (!extra_ff && wi_ff == LEN_LO_IDX) begin
         fill_word = {cnt_ff[WORD_W-4:0], 3'b000};
      end
   end

   // round datapath
   always_comb begin
      if (rnd_ff < 6'd16) begin
         w_cur = rd_data_ff;
      end else begin
         w_cur = ssig1(win_ff[1]) + win_ff[6] + ssig0(win_ff[14]) + win_ff[15];
      end
      ch  = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      maj = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t1  = wv_ff[7] + bsig1(wv_ff[4]) + ch + ROUND_K[rnd_ff] + w_cur;
      t2  = bsig0(wv_ff[0]) + maj;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser && cnt_ff[5:0] == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (req_tlast) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_LOAD: state_in = ST_ROUND;
         ST_ROUND: begin
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            priority if (!pad_ff) begin
               state_in = last_pend_ff ? ST_PAD_MARK : ST_IDLE;
            end else if (extra_ff) begin
               state_in = ST_PAD_FILL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_PAD_MARK: begin
            state_in = (idx == LEN_LO_IDX) ? ST_LOAD : ST_PAD_FILL;
         end
         ST_PAD_FILL: begin
            if (wi_ff == LEN_LO_IDX) begin
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (rsp_acc && oi_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = idx;
      mem_wdata  = byte_word;
      rd_addr    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_we     = req_acc && req_tuser && bpos == 2'd3;
         end
         ST_ROUND: rd_addr = rnd_ff[BUF_AW-1:0] + 1'b1;
         ST_PAD_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = mark_word;
         end
         ST_PAD_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = wi_ff;
            mem_wdata = fill_word;
         end
         ST_OUT: rsp_tvalid = 1'b1;
         ST_LOAD, ST_FINAL: ;
         default: ;
      endcase
   end

   assign rsp_tdata = hash_ff[oi_ff];
   assign rsp_tuser = oi_ff;
   assign rsp_tlast = (oi_ff == LAST_WORD);

   // register updates
   always_comb begin
      cnt_in       = cnt_ff;
      hash_in      = hash_ff;
      wv_in        = wv_ff;
      win_in       = win_ff;
      acc_in       = acc_ff;
      rnd_in       = rnd_ff;
      wi_in        = wi_ff;
      oi_in        = oi_ff;
      pad_in       = pad_ff;
      extra_in     = extra_ff;
      last_pend_in = last_pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser) begin
               acc_in       = byte_word;
               cnt_in       = cnt_ff + 1'b1;
               last_pend_in = req_tlast;
            end
         end
         ST_LOAD: begin
            wv_in  = hash_ff;
            rnd_in = '0;
         end
         ST_ROUND: begin
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            for (int i = BUF_DEPTH - 1; i > 0; i--) begin
               win_in[i] = win_ff[i-1];
            end
            win_in[0] = w_cur;
            rnd_in    = rnd_ff + 1'b1;
         end
         ST_FINAL: begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               hash_in[i] = hash_ff[i] + wv_ff[i];
            end
            if (pad_ff && extra_ff) begin
               extra_in = 1'b0;
               wi_in    = '0;
            end
            oi_in = '0;
         end
         ST_PAD_MARK: begin
            pad_in       = 1'b1;
            last_pend_in = 1'b0;
            extra_in     = (idx >= LEN_HI_IDX);
            wi_in        = idx + 1'b1;
         end
         ST_PAD_FILL: wi_in = wi_ff + 1'b1;
         ST_OUT: begin
            if (rsp_acc) begin
               oi_in = oi_ff + 1'b1;
               if (oi_ff == LAST_WORD) begin
                  hash_in = INIT_HASH;
                  cnt_in  = '0;
                  pad_in  = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         hash_ff      <= INIT_HASH;
         oi_ff        <= '0;
         pad_ff       <= 1'b0;
         extra_ff     <= 1'b0;
         last_pend_ff <= 1'b0;
         rnd_ff       <= '0;
         wi_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hash_ff      <= hash_in;
         oi_ff        <= oi_in;
         pad_ff       <= pad_in;
         extra_ff     <= extra_in;
         last_pend_ff <= last_pend_in;
         rnd_ff       <= rnd_in;
         wi_ff        <= wi_in;
      end
   end

   always_ff @(posedge clock) begin
      wv_ff  <= wv_in;
      win_ff <= win_in;
      acc_ff <= acc_in;
   end

   // block buffer, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= buf_mem[rd_addr];
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while digest pending");

   a_first_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tuser == 3'd0)
      else $error("digest does not start at word zero");

   a_round_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff != LAST_ROUND) |=>
         (state_ff == ST_ROUND && rnd_ff == $past(rnd_ff) + 6'd1))
      else $error("round counter skipped");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_tlast) |=> (req_tready && cnt_ff == '0 && hash_ff[0] == INIT_HASH[0]))
      else $error("hash not restarted after digest");

endmodule

// ===== tb/sha256_message_hash_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sha256_message_hash_unit: byte messages in, digest words out,
// checked against an in-bench SHA-256 model. Needs sha256_pkg and the unit RTL.
module sha256_message_hash_unit_test;
   import sha256_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 300;
   localparam int ITEM_TARGET  = 410;

   typedef struct {
      logic [7:0] data;
      logic       has_byte;
      logic       is_last;
   } byte_req_t;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] has_byte
   logic        req_tlast = 1'b0;    // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [31:0] digest_word
   logic [2:0]  rsp_tuser;           // [2:0] word_index
   logic        rsp_tlast;           // last_word

   byte_req_t    pending_reqs[$];
   digest_beat_t digests_due[$];
   int           mismatch_count = 0;
   int           queued_items = 0;
   int           accepted_items = 0;

   // model state
   logic [31:0] hash_state [8];
   logic [31:0] block_words [16];
   logic [60:0] byte_count;

   sha256_message_hash_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sched_sigma0(input logic [31:0] x);
      return rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sched_sigma1(input logic [31:0] x);
      return rot_right(x, 17) ^ rot_right(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] round_sigma0(input logic [31:0] x);
      return rot_right(x, 2) ^ rot_right(x, 13) ^ rot_right(x, 22);
   endfunction

   function automatic logic [31:0] round_sigma1(input logic [31:0] x);
      return rot_right(x, 6) ^ rot_right(x, 11) ^ rot_right(x, 25);
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++)
         hash_state[i] = INIT_HASH[i];
      byte_count = '0;
   endtask

   task automatic absorb_block();
      logic [31:0] sched [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         sched[i] = block_words[i];
      for (int i = 16; i < 64; i++)
         sched[i] = sched_sigma1(sched[i-2]) + sched[i-7] + sched_sigma0(sched[i-15])
                    + sched[i-16];
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + round_sigma1(e) + ((e & f) ^ (~e & g)) + ROUND_K[i] + sched[i];
         t2 = round_sigma0(a) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   // big-endian byte placement; first byte of a word clears the rest
   task automatic insert_byte(input int pos, input logic [7:0] b);
      int idx;
      int sh;
      idx = pos / 4;
      sh  = (3 - pos % 4) * 8;
      if (pos % 4 == 0)
         block_words[idx] = 32'(b) << sh;
      else
         block_words[idx] |= 32'(b) << sh;
   endtask

   task automatic hash_request(input logic [7:0] data, input logic has_byte,
                               input logic is_last);
      int pos;
      logic [63:0] bit_len;
      digest_beat_t beat;
      if (has_byte) begin
         pos = int'(byte_count[5:0]);
         insert_byte(pos, data);
         byte_count = byte_count + 61'd1;
         if (pos == 63)
            absorb_block();
      end
      if (!is_last)
         return;
      pos = int'(byte_count[5:0]);
      insert_byte(pos, PAD_BYTE);
      pos++;
      // no room for the length: spill into an extra block
      if (pos > 56) begin
         while (pos < 64) begin
            insert_byte(pos, 8'h00);
            pos++;
         end
         absorb_block();
         pos = 0;
      end
      while (pos < 56) begin
         insert_byte(pos, 8'h00);
         pos++;
      end
      bit_len = {byte_count, 3'b000};
      block_words[LEN_HI_IDX] = bit_len[63:32];
      block_words[LEN_LO_IDX] = bit_len[31:0];
      absorb_block();
      for (int i = 0; i < 8; i++) begin
         beat.word  = hash_state[i];
         beat.index = 3'(i);
         beat.last  = (i == 7);
         digests_due.push_back(beat);
      end
      restart_hash();
   endtask

   task automatic queue_request(input logic [7:0] data, input logic has_byte,
                                input logic is_last);
      byte_req_t r;
      r.data     = data;
      r.has_byte = has_byte;
      r.is_last  = is_last;
      pending_reqs.push_back(r);
      queued_items++;
   endtask

   // message of random bytes, some noise requests mixed in, last mark on the
   // final byte or on a separate byte-less request
   task automatic queue_message(input int len, input bit last_on_byte);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 5)
            queue_request(8'($urandom), 1'b0, 1'b0);
         queue_request(8'($urandom), 1'b1, last_on_byte && (i == len - 1));
      end
      if (!last_on_byte || len == 0)
         queue_request(8'($urandom), 1'b0, 1'b1);
   endtask

   // request driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      byte_req_t next_req;
      logic      launch;
      logic      holding;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tuser  <= 1'b0;
         req_tlast  <= 1'b0;
      end else begin
         launch = 1'b0;
         if (req_tvalid && req_tready) begin
            hash_request(req_tdata, req_tuser, req_tlast);
            accepted_items++;
         end
         holding = req_tvalid && !req_tready;
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               next_req = pending_reqs.pop_front();
               launch = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_tvalid <= launch;
            if (launch) begin
               req_tdata <= next_req.data;
               req_tuser <= next_req.has_byte;
               req_tlast <= next_req.is_last;
            end
         end
      end
   end

   // digest monitor; ready stall rate is re-picked at random
   int stall_pct = 0;
   int stall_cycles = 0;

   always @(posedge clock) begin
      digest_beat_t exp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digests_due.size() == 0) begin
               report_mismatch($sformatf("unexpected digest word %h index %0d",
                                         rsp_tdata, rsp_tuser));
            end else begin
               exp = digests_due.pop_front();
               if (rsp_tdata !== exp.word)
                  report_mismatch($sformatf("digest_word %h, want %h (index %0d)",
                                            rsp_tdata, exp.word, exp.index));
               if (rsp_tuser !== exp.index)
                  report_mismatch($sformatf("word_index %0d, want %0d",
                                            rsp_tuser, exp.index));
               if (rsp_tlast !== exp.last)
                  report_mismatch($sformatf("last_word %b, want %b (index %0d)",
                                            rsp_tlast, exp.last, exp.index));
            end
         end
         stall_cycles++;
         if (stall_cycles % 300 == 0) begin
            case ($urandom_range(0, 4))
               0, 1: stall_pct = 0;
               2: stall_pct = 25;
               3: stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         rsp_tready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   // watchdog on cycles with no handshake on either side
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int len;
      int pick;
      restart_hash();
      for (int i = 0; i < 16; i++)
         block_words[i] = '0;

      // directed: empty message, single extreme bytes, noise, "abc"
      queue_request(8'hff, 1'b0, 1'b1);
      queue_request(8'h00, 1'b1, 1'b1);
      queue_request(8'hff, 1'b1, 1'b0);
      queue_request(8'h00, 1'b0, 1'b1);
      queue_request(8'hff, 1'b0, 1'b0);
      queue_request(8'h61, 1'b1, 1'b0);
      queue_request(8'h00, 1'b0, 1'b0);
      queue_request(8'h62, 1'b1, 1'b0);
      queue_request(8'h63, 1'b1, 1'b1);
      queue_request(8'h00, 1'b0, 1'b1);
      queue_request(8'h80, 1'b1, 1'b0);
      queue_request(8'h7f, 1'b1, 1'b0);
      queue_request(8'h55, 1'b0, 1'b1);

      while (queued_items < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3, 4: len = $urandom_range(0, 12);
            5, 6: len = $urandom_range(13, 50);
            7: len = $urandom_range(55, 57) + (($urandom_range(0, 1) == 1) ? 8 : 0);
            8: len = $urandom_range(0, 3);
            default: len = $urandom_range(119, 129);
         endcase
         if (len > ITEM_TARGET - queued_items)
            len = ITEM_TARGET - queued_items;
         queue_message(len, 1'($urandom_range(0, 1)));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted_items < queued_items)
         @(posedge clock);
      while (digests_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sha256_pkg.sv
rtl/sha256_message_hash_unit.sv
tb/sha256_message_hash_unit_test.sv
